// File: rtl/core/sblc_pkg.sv
// types, sizes and codes shared by the size-budgeted lru tracker
`default_nettype none

package sblc_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = 16;
    localparam int SIZE_W = 32;
    localparam int EVC_W  = 5;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [DATA_W-1:0] BUDGET_RST = 32'd65536;

    // register index, taken from paddr above the byte offset
    localparam logic REG_BUDGET = 1'b0;

    typedef struct packed {
        logic [KEY_W-1:0]  item_key;
        logic [SIZE_W-1:0] item_size;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic              stored;
        logic [EVC_W-1:0]  evicted_count;
        logic [SIZE_W-1:0] bytes_in_use;
    } rsp_t;

    // one slot of the table
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  rank;
    } slot_t;

    // victim list entry, addressed by recency rank
    typedef struct packed {
        logic [IDX_W-1:0]  slot;
        logic [SIZE_W-1:0] size;
    } victim_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_EVICT_CHK,
        ST_EVICT_APPLY,
        ST_UPDATE,
        ST_INSERT,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/sblc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module sblc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/size_budget_lru_cache_tracker_top.sv
// top level of the size-budgeted lru cache tracker
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  request   | in        | req_valid / req_stall      | req_t: item_key, item_size
//  response  | out       | rsp_valid / rsp_stall      | rsp_t: hit, stored, count, bytes
//  config    | in        | apb psel/penable/pwrite    | memory_budget at byte address 0
//
//  one item at a time; the work per item is set by the slot table sweeps and by evictions,
//  and the sweeps read one entry per cycle through one read port
//  reset clears valid bits, fill count and bytes in use and sets the budget to 65536; the ram needs no clear
//  the response register holds a finished item while the next request is accepted
//  a stalled response only delays the return to idle after the next item's work
`default_nettype none

module size_budget_lru_cache_tracker_top (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sblc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sblc_pkg::DATA_W-1:0]  pwdata,
    output logic [sblc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // requests
    input  logic                         req_valid,
    output logic                         req_stall,
    input  sblc_pkg::req_t               req,
    // responses
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output sblc_pkg::rsp_t               rsp
);

    localparam int IDX_W = sblc_pkg::IDX_W;
    localparam int CNT_W = sblc_pkg::CNT_W;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    sblc_pkg::state_t state_reg, state_next;

    // budget register
    logic [sblc_pkg::DATA_W-1:0] budget_reg, budget_next;

    // per-slot valid bits, fill count and bytes in use live in flops, slot entries in ram
    logic [sblc_pkg::SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [sblc_pkg::SIZE_W-1:0] used_reg, used_next;

    // item being worked on
    logic [sblc_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [sblc_pkg::SIZE_W-1:0] size_reg, size_next;
    logic                        found_reg, found_next;
    logic [IDX_W-1:0]            found_idx_reg, found_idx_next;
    logic [IDX_W-1:0]            found_rank_reg, found_rank_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic                        stored_reg, stored_next;
    logic [sblc_pkg::EVC_W-1:0]  evicted_reg, evicted_next;

    // sweep pointer and read pipeline tag
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0] pipe_idx_reg, pipe_idx_next;

    // response register
    logic           rsp_valid_reg, rsp_valid_next;
    sblc_pkg::rsp_t rsp_reg, rsp_next;

    // ------------------------------------------------------------------
    // memories: slot table by slot index, victim list by recency rank
    // ------------------------------------------------------------------
    logic              slot_re, slot_we;
    logic [IDX_W-1:0]  slot_raddr, slot_waddr;
    sblc_pkg::slot_t   slot_rdata, slot_wdata;

    logic              vic_re, vic_we;
    logic [IDX_W-1:0]  vic_raddr, vic_waddr;
    sblc_pkg::victim_t vic_rdata, vic_wdata;

    sblc_ram #(
        .WIDTH ($bits(sblc_pkg::slot_t)),
        .DEPTH (sblc_pkg::SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    sblc_ram #(
        .WIDTH ($bits(sblc_pkg::victim_t)),
        .DEPTH (sblc_pkg::SLOTS)
    ) u_victim_ram (
        .clk   (clk),
        .we    (vic_we),
        .waddr (vic_waddr),
        .wdata (vic_wdata),
        .re    (vic_re),
        .raddr (vic_raddr),
        .rdata (vic_rdata)
    );

    // ------------------------------------------------------------------
    // shared helpers
    // ------------------------------------------------------------------
    logic                          sweeping;
    logic                          sweep_issue;
    logic                          sweep_last;
    logic [sblc_pkg::SIZE_W:0]     need_sum;
    logic                          over_budget;
    logic                          evict_go;
    logic [CNT_W-1:0]              cnt_dec;
    logic [IDX_W-1:0]              first_free;
    logic                          rsp_free;

    assign sweeping    = (state_reg == sblc_pkg::ST_LOOKUP) ||
                         (state_reg == sblc_pkg::ST_UPDATE) ||
                         (state_reg == sblc_pkg::ST_INSERT);
    assign sweep_issue = sweeping && (ptr_reg != CNT_W'(sblc_pkg::SLOTS));
    assign sweep_last  = pipe_vld_reg && (pipe_idx_reg == IDX_W'(sblc_pkg::SLOTS - 1));

    // 33-bit sum so the fit test never wraps
    assign need_sum    = {1'b0, used_reg} + {1'b0, size_reg};
    assign over_budget = need_sum > {1'b0, budget_reg};

    // evict while the item does not fit, then once more if every slot is taken
    assign evict_go = (over_budget && (cnt_reg != '0)) ||
                      (cnt_reg == CNT_W'(sblc_pkg::SLOTS));
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // lowest-numbered empty slot
    always_comb
    begin
        first_free = '0;
        for (int i = sblc_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                first_free = IDX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[sblc_pkg::ADDR_W-1] == sblc_pkg::REG_BUDGET) ? budget_reg : '0;

    always_comb
    begin
        budget_next = budget_reg;
        if (psel && penable && pwrite && pready &&
            (paddr[sblc_pkg::ADDR_W-1] == sblc_pkg::REG_BUDGET))
        begin
            budget_next = pwdata;
        end
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sblc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sblc_pkg::ST_LOOKUP;
                end
            end
            sblc_pkg::ST_LOOKUP:
            begin
                if (sweep_last)
                begin
                    state_next = sblc_pkg::ST_DECIDE;
                end
            end
            sblc_pkg::ST_DECIDE:
            begin
                if (found_reg)
                begin
                    state_next = sblc_pkg::ST_UPDATE;
                end
                else if (size_reg > budget_reg)
                begin
                    state_next = sblc_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = sblc_pkg::ST_EVICT_CHK;
                end
            end
            sblc_pkg::ST_EVICT_CHK:
            begin
                if (evict_go)
                begin
                    state_next = sblc_pkg::ST_EVICT_APPLY;
                end
                else
                begin
                    state_next = sblc_pkg::ST_INSERT;
                end
            end
            sblc_pkg::ST_EVICT_APPLY:
            begin
                state_next = sblc_pkg::ST_EVICT_CHK;
            end
            sblc_pkg::ST_UPDATE,
            sblc_pkg::ST_INSERT:
            begin
                if (sweep_last)
                begin
                    state_next = sblc_pkg::ST_RESULT;
                end
            end
            sblc_pkg::ST_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = sblc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sblc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs and datapath
    // ------------------------------------------------------------------
    assign req_stall = (state_reg != sblc_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        // memory defaults: sweep reads at the pointer, writes back the tagged entry
        slot_re    = sweep_issue;
        slot_raddr = ptr_reg[IDX_W-1:0];
        slot_we    = 1'b0;
        slot_waddr = pipe_idx_reg;
        slot_wdata = slot_rdata;

        vic_re         = 1'b0;
        vic_raddr      = cnt_dec[IDX_W-1:0];
        vic_we         = 1'b0;
        vic_waddr      = slot_rdata.rank;
        vic_wdata.slot = pipe_idx_reg;
        vic_wdata.size = slot_rdata.size;

        ptr_next      = sweep_issue ? (ptr_reg + CNT_W'(1)) : ptr_reg;
        pipe_vld_next = sweep_issue;
        pipe_idx_next = ptr_reg[IDX_W-1:0];

        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_rank_next = found_rank_reg;
        free_idx_next   = free_idx_reg;
        stored_next     = stored_reg;
        evicted_next    = evicted_reg;

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        if (sweep_last)
        begin
            ptr_next = '0;
        end

        case (state_reg)
            sblc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next     = req.item_key;
                    size_next    = req.item_size;
                    found_next   = 1'b0;
                    stored_next  = 1'b0;
                    evicted_next = '0;
                end
            end
            sblc_pkg::ST_LOOKUP:
            begin
                // compare keys and build the rank-ordered victim list
                if (pipe_vld_reg && valid_reg[pipe_idx_reg])
                begin
                    vic_we = 1'b1;
                    if (!found_reg && (slot_rdata.key == key_reg))
                    begin
                        found_next      = 1'b1;
                        found_idx_next  = pipe_idx_reg;
                        found_rank_next = slot_rdata.rank;
                    end
                end
            end
            sblc_pkg::ST_DECIDE:
            begin
            end
            sblc_pkg::ST_EVICT_CHK:
            begin
                // least recent entry has rank cnt-1
                if (evict_go)
                begin
                    vic_re = 1'b1;
                end
                else
                begin
                    free_idx_next = first_free;
                end
            end
            sblc_pkg::ST_EVICT_APPLY:
            begin
                valid_next[vic_rdata.slot] = 1'b0;
                used_next    = used_reg - vic_rdata.size;
                cnt_next     = cnt_dec;
                evicted_next = evicted_reg + sblc_pkg::EVC_W'(1);
            end
            sblc_pkg::ST_UPDATE:
            begin
                // hit: entry goes to rank 0, more recent ones age by one
                if (pipe_vld_reg)
                begin
                    if (pipe_idx_reg == found_idx_reg)
                    begin
                        slot_we         = 1'b1;
                        slot_wdata.rank = '0;
                    end
                    else if (valid_reg[pipe_idx_reg] && (slot_rdata.rank < found_rank_reg))
                    begin
                        slot_we         = 1'b1;
                        slot_wdata.rank = slot_rdata.rank + IDX_W'(1);
                    end
                end
                if (sweep_last)
                begin
                    stored_next = 1'b1;
                end
            end
            sblc_pkg::ST_INSERT:
            begin
                // insert: new entry at rank 0, all others age by one
                if (pipe_vld_reg)
                begin
                    if (pipe_idx_reg == free_idx_reg)
                    begin
                        slot_we         = 1'b1;
                        slot_wdata.key  = key_reg;
                        slot_wdata.size = size_reg;
                        slot_wdata.rank = '0;
                    end
                    else if (valid_reg[pipe_idx_reg])
                    begin
                        slot_we         = 1'b1;
                        slot_wdata.rank = slot_rdata.rank + IDX_W'(1);
                    end
                end
                if (sweep_last)
                begin
                    valid_next[free_idx_reg] = 1'b1;
                    used_next   = used_reg + size_reg;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    stored_next = 1'b1;
                end
            end
            sblc_pkg::ST_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.hit           = found_reg;
                    rsp_next.stored        = stored_reg;
                    rsp_next.evicted_count = evicted_reg;
                    rsp_next.bytes_in_use  = used_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sblc_pkg::ST_IDLE;
            budget_reg    <= sblc_pkg::BUDGET_RST;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            used_reg      <= '0;
            found_reg     <= 1'b0;
            stored_reg    <= 1'b0;
            evicted_reg   <= '0;
            ptr_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            budget_reg    <= budget_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            found_reg     <= found_next;
            stored_reg    <= stored_next;
            evicted_reg   <= evicted_next;
            ptr_reg       <= ptr_next;
            pipe_vld_reg  <= pipe_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        size_reg       <= size_next;
        found_idx_reg  <= found_idx_next;
        found_rank_reg <= found_rank_next;
        free_idx_reg   <= free_idx_next;
        pipe_idx_reg   <= pipe_idx_next;
        rsp_reg        <= rsp_next;
    end

`ifndef NO_ASSERTIONS
    // fill count tracks the valid bits
    a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CNT_W'($countones(valid_reg)))
        else $error("fill count does not match valid bits");

    // the victim list entry read for an eviction names a live slot
    a_victim_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sblc_pkg::ST_EVICT_APPLY) |-> valid_reg[vic_rdata.slot])
        else $error("eviction of an empty slot");

    // insertion only into an empty slot with room left
    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sblc_pkg::ST_INSERT) |->
            (!valid_reg[free_idx_reg] && (cnt_reg != CNT_W'(sblc_pkg::SLOTS))))
        else $error("insert target is occupied");

    // a hit stores and evicts nothing
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.hit) |-> (rsp_reg.stored && (rsp_reg.evicted_count == '0)))
        else $error("hit reported with evictions");
`endif

endmodule

`default_nettype wire
